// ===== design/a5mmu_pkg.sv =====
// ----------------------------------------------------------------------------
// ARMv5 MMU page walk package
// Shared types and constants for the short-descriptor page table walker.
// ----------------------------------------------------------------------------
package a5mmu_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);

	// Command carried by an input item.
	typedef enum logic [1:0] {
		CMD_TRANSLATE = 2'd0,
		CMD_DESC      = 2'd1,
		CMD_LOAD      = 2'd2
	} cmd_t;

	// Kind of a result item.
	typedef enum logic [1:0] {
		KIND_OK     = 2'd0,
		KIND_FETCH  = 2'd1,
		KIND_FAULT  = 2'd2,
		KIND_ACCEPT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		FT_NONE        = 2'd0,
		FT_TRANSLATION = 2'd1,
		FT_DOMAIN      = 2'd2,
		FT_PERMISSION  = 2'd3
	} fault_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_MMU_ENABLE    = 2'd0,
		REG_SYS_ROM       = 2'd1,
		REG_DOMAIN_ACCESS = 2'd2
	} reg_idx_t;

	// First-level descriptor types.
	localparam logic [1:0] L1_FAULT   = 2'd0;
	localparam logic [1:0] L1_COARSE  = 2'd1;
	localparam logic [1:0] L1_SECTION = 2'd2;
	localparam logic [1:0] L1_FINE    = 2'd3;

	// Second-level descriptor types.
	localparam logic [1:0] L2_LARGE = 2'd1;
	localparam logic [1:0] L2_SMALL = 2'd2;
	localparam logic [1:0] L2_TINY  = 2'd3;

	// Domain access codes.
	localparam logic [1:0] DA_MANAGER = 2'd3;

	// Offset masks for each mapping size.
	localparam logic [31:0] MASK_SECTION = 32'h000F_FFFF;
	localparam logic [31:0] MASK_LARGE   = 32'h0000_FFFF;
	localparam logic [31:0] MASK_SMALL   = 32'h0000_0FFF;
	localparam logic [31:0] MASK_TINY    = 32'h0000_03FF;

	localparam logic [31:0] FAULT_ADDR = 32'hFFFF_FFFF;

endpackage

// ===== design/a5mmu_req_if.sv =====
// ----------------------------------------------------------------------------
// ARMv5 MMU request channel
// Valid/ready channel that carries one walker input item.
// ----------------------------------------------------------------------------
interface a5mmu_req_if
	import a5mmu_pkg::*;
;
	logic        valid;
	logic        ready;
	cmd_t        cmd;
	logic [31:0] virt_addr;
	logic        is_write;
	logic        user_access;
	logic [31:0] descriptor;
	logic [11:0] table_index;

	modport source (
		output valid, cmd, virt_addr, is_write, user_access, descriptor, table_index,
		input  ready
	);
	modport sink (
		input  valid, cmd, virt_addr, is_write, user_access, descriptor, table_index,
		output ready
	);
endinterface

// ===== design/a5mmu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ARMv5 MMU response channel
// Valid/ready channel that carries one walker result item.
// ----------------------------------------------------------------------------
interface a5mmu_rsp_if
	import a5mmu_pkg::*;
;
	logic        valid;
	logic        ready;
	kind_t       result_kind;
	logic [31:0] out_addr;
	fault_t      fault_type;
	logic        fault_on_page;
	logic [3:0]  fault_domain;

	modport source (
		output valid, result_kind, out_addr, fault_type, fault_on_page, fault_domain,
		input  ready
	);
	modport sink (
		input  valid, result_kind, out_addr, fault_type, fault_on_page, fault_domain,
		output ready
	);
endinterface

// ===== design/armv5_mmu_page_walk_top.sv =====
// ----------------------------------------------------------------------------
// ARMv5 MMU page walk
// Short-descriptor translation with a stored first-level table.
// ----------------------------------------------------------------------------
// An input item is taken into stage one with its registered table read, and its
// result item is offered from the output register once it moves on from there.
// Throughput: one item per cycle while the result channel is not stalled; each
// item makes one access to the table memory: a read, or a write for a load item.
// Reset (arst_n low) clears the control registers, the open walk and both
// pipeline valids; the table memory keeps no reset and is undefined until
// load items have written it.
// ----------------------------------------------------------------------------
module armv5_mmu_page_walk_top
	import a5mmu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_idx,
	input  logic [31:0]       cfg_wdata,
	a5mmu_req_if.sink         req,
	a5mmu_rsp_if.source       rsp
);

	// The first-level table lives in a single-port synchronous memory. An item
	// either reads it (the read address is the section index of the virtual
	// address) or, for a load item, writes it; never both. Because items reach
	// the memory in order, a load is always written before any later item reads,
	// so no forwarding is needed.
	logic [31:0] tbl_mem [TABLE_ENTRIES];
	logic [31:0] tbl_rd_s1;

	// Configuration registers.
	logic        mmu_en_q;
	logic [1:0]  sys_rom_q;
	logic [31:0] dom_acc_q;

	// Stage one holds the item while the table word comes back.
	logic        v_s1;
	cmd_t        cmd_s1;
	logic [31:0] vaddr_s1;
	logic        wr_s1;
	logic        user_s1;
	logic [31:0] desc_s1;

	// The open walk.
	logic        pend_q;
	logic [31:0] pend_vaddr_q;
	logic        pend_wr_q;
	logic        pend_user_q;
	logic [3:0]  pend_dom_q;

	// Output register.
	logic        out_valid_q;
	kind_t       out_kind_q;
	logic [31:0] out_addr_q;
	fault_t      out_ft_q;
	logic        out_page_q;
	logic [3:0]  out_dom_q;

	logic acc;
	logic adv;

	// An item moves out of stage one whenever the output register is free or
	// is being emptied in the same cycle; stage one then takes a new item.
	assign adv       = v_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !v_s1 || adv;
	assign acc       = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (acc) begin
			if (req.cmd == CMD_LOAD) begin
				tbl_mem[req.table_index] <= req.descriptor;
			end else begin
				tbl_rd_s1 <= tbl_mem[req.virt_addr[31 -: TABLE_AW]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mmu_en_q  <= 1'b0;
			sys_rom_q <= 2'b00;
			dom_acc_q <= 32'd0;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_MMU_ENABLE:    mmu_en_q  <= cfg_wdata[0];
				REG_SYS_ROM:       sys_rom_q <= cfg_wdata[1:0];
				REG_DOMAIN_ACCESS: dom_acc_q <= cfg_wdata;
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1   <= req.cmd;
			vaddr_s1 <= req.virt_addr;
			wr_s1    <= req.is_write;
			user_s1  <= req.user_access;
			desc_s1  <= req.descriptor;
		end
	end

	// ------------------------------------------------------------------------
	// Walk evaluation for the item in stage one.
	// ------------------------------------------------------------------------
	logic [3:0]  entry_dom;
	logic [7:0]  ap_field;
	logic [1:0]  sub_idx;
	logic        pend_nxt;
	logic        pend_set;

	logic        fin_go;
	logic [31:0] fin_vaddr;
	logic        fin_wr;
	logic        fin_user;
	logic [3:0]  fin_dom;
	logic        fin_page;
	logic [1:0]  fin_ap;
	logic [31:0] fin_base;
	logic [31:0] fin_mask;

	logic [1:0]  dom_code;
	logic        deny;

	kind_t       res_kind;
	logic [31:0] res_addr;
	fault_t      res_ft;
	logic        res_page;
	logic [3:0]  res_dom;

	assign entry_dom = tbl_rd_s1[8:5];
	assign ap_field  = desc_s1[11:4];

	always_comb begin
		pend_nxt  = pend_q;
		pend_set  = 1'b0;
		fin_go    = 1'b0;
		fin_vaddr = vaddr_s1;
		fin_wr    = wr_s1;
		fin_user  = user_s1;
		fin_dom   = entry_dom;
		fin_page  = 1'b0;
		fin_ap    = tbl_rd_s1[11:10];
		fin_base  = tbl_rd_s1;
		fin_mask  = MASK_SECTION;
		sub_idx   = 2'b00;
		res_kind  = KIND_ACCEPT;
		res_addr  = 32'd0;
		res_ft    = FT_NONE;
		res_page  = 1'b0;
		res_dom   = 4'd0;

		case (cmd_s1)
			CMD_TRANSLATE: begin
				// Any translate closes a walk that was left open.
				pend_nxt = 1'b0;
				if (!mmu_en_q) begin
					res_kind = KIND_OK;
					res_addr = vaddr_s1;
				end else begin
					case (tbl_rd_s1[1:0])
						L1_COARSE: begin
							pend_nxt = 1'b1;
							pend_set = 1'b1;
							res_kind = KIND_FETCH;
							res_addr = {tbl_rd_s1[31:10], vaddr_s1[19:12], 2'b00};
						end
						L1_FINE: begin
							pend_nxt = 1'b1;
							pend_set = 1'b1;
							res_kind = KIND_FETCH;
							res_addr = {tbl_rd_s1[31:12], vaddr_s1[19:10], 2'b00};
						end
						L1_SECTION: begin
							fin_go = 1'b1;
						end
						default: begin
							res_kind = KIND_FAULT;
							res_addr = FAULT_ADDR;
							res_ft   = FT_TRANSLATION;
							res_dom  = entry_dom;
						end
					endcase
				end
			end
			CMD_DESC: begin
				if (pend_q) begin
					pend_nxt  = 1'b0;
					fin_vaddr = pend_vaddr_q;
					fin_wr    = pend_wr_q;
					fin_user  = pend_user_q;
					fin_dom   = pend_dom_q;
					fin_page  = 1'b1;
					fin_base  = desc_s1;
					case (desc_s1[1:0])
						L2_LARGE: begin
							fin_go   = 1'b1;
							sub_idx  = pend_vaddr_q[15:14];
							fin_ap   = ap_field[{sub_idx, 1'b0} +: 2];
							fin_mask = MASK_LARGE;
						end
						L2_SMALL: begin
							fin_go   = 1'b1;
							sub_idx  = pend_vaddr_q[11:10];
							fin_ap   = ap_field[{sub_idx, 1'b0} +: 2];
							fin_mask = MASK_SMALL;
						end
						L2_TINY: begin
							fin_go   = 1'b1;
							fin_ap   = desc_s1[5:4];
							fin_mask = MASK_TINY;
						end
						default: begin
							res_kind = KIND_FAULT;
							res_addr = FAULT_ADDR;
							res_ft   = FT_TRANSLATION;
							res_page = 1'b1;
							res_dom  = pend_dom_q;
						end
					endcase
				end
			end
			default: begin
				res_kind = KIND_ACCEPT;
			end
		endcase

		// Domain and permission checks, then address formation.
		dom_code = dom_acc_q[{fin_dom, 1'b0} +: 2];
		case (fin_ap)
			2'd0: begin
				// AP of zero defers to S and R; both set is reserved and denies.
				case (sys_rom_q)
					2'd1:    deny = fin_user || fin_wr;
					2'd2:    deny = fin_wr;
					default: deny = 1'b1;
				endcase
			end
			2'd1:    deny = fin_user;
			2'd2:    deny = fin_wr && fin_user;
			default: deny = 1'b0;
		endcase

		if (fin_go) begin
			if (dom_code != DA_MANAGER && !dom_code[0]) begin
				res_kind = KIND_FAULT;
				res_addr = FAULT_ADDR;
				res_ft   = FT_DOMAIN;
				res_page = fin_page;
				res_dom  = fin_dom;
			end else if (dom_code != DA_MANAGER && deny) begin
				res_kind = KIND_FAULT;
				res_addr = FAULT_ADDR;
				res_ft   = FT_PERMISSION;
				res_page = fin_page;
				res_dom  = fin_dom;
			end else begin
				res_kind = KIND_OK;
				res_addr = (fin_base & ~fin_mask) | (fin_vaddr & fin_mask);
			end
		end
	end

	// The open walk is updated as its item leaves stage one, so the next item
	// in stage one always sees the state left by the one before it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= 1'b0;
			pend_vaddr_q <= 32'd0;
			pend_wr_q    <= 1'b0;
			pend_user_q  <= 1'b0;
			pend_dom_q   <= 4'd0;
		end else if (adv) begin
			pend_q <= pend_nxt;
			if (pend_set) begin
				pend_vaddr_q <= vaddr_s1;
				pend_wr_q    <= wr_s1;
				pend_user_q  <= user_s1;
				pend_dom_q   <= entry_dom;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_kind_q <= res_kind;
			out_addr_q <= res_addr;
			out_ft_q   <= res_ft;
			out_page_q <= res_page;
			out_dom_q  <= res_dom;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.result_kind   = out_kind_q;
	assign rsp.out_addr      = out_addr_q;
	assign rsp.fault_type    = out_ft_q;
	assign rsp.fault_on_page = out_page_q;
	assign rsp.fault_domain  = out_dom_q;

endmodule

// ===== design/a5mmu_checker.sv =====
// ----------------------------------------------------------------------------
// ARMv5 MMU page walk checker
// Port-level assertions on the result channel of the walker.
// ----------------------------------------------------------------------------
module a5mmu_checker
	import a5mmu_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input kind_t       rsp_kind,
	input logic [31:0] rsp_addr,
	input fault_t      rsp_ft,
	input logic        rsp_page,
	input logic [3:0]  rsp_dom
);

	// A stalled result stays offered with the same address.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr))
		else $error("stalled result item changed");

	// A fault carries the all-ones address and a real fault type.
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_FAULT |-> rsp_addr == FAULT_ADDR && rsp_ft != FT_NONE)
		else $error("fault item without fault address or type");

	// Anything that is not a fault reports no fault details.
	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind != KIND_FAULT |-> rsp_ft == FT_NONE && !rsp_page && rsp_dom == 4'd0)
		else $error("fault details on a non-fault item");

	// Descriptor fetch addresses are word aligned; accepted-only items carry zero.
	a_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_FETCH || rsp_kind == KIND_ACCEPT) |->
		rsp_addr[1:0] == 2'b00 && (rsp_kind == KIND_FETCH || rsp_addr == 32'd0))
		else $error("bad fetch or accepted-only address");

endmodule

bind armv5_mmu_page_walk_top a5mmu_checker u_a5mmu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.result_kind),
	.rsp_addr  (rsp.out_addr),
	.rsp_ft    (rsp.fault_type),
	.rsp_page  (rsp.fault_on_page),
	.rsp_dom   (rsp.fault_domain)
);

// ===== tb/sv/tb_a5mmu_walk_check.sv =====
// ----------------------------------------------------------------------------
// ARMv5 MMU page walk checker
// Follows both channels and the register port, works out the result each
// accepted item should give and compares it field by field with the block.
// ----------------------------------------------------------------------------
module tb_a5mmu_walk_check
	import a5mmu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata,
	a5mmu_req_if        req,
	a5mmu_rsp_if        rsp,
	output int          outstanding,
	output int          errors,
	output int          seen_ok,
	output int          seen_fetch,
	output int          seen_fault
);

	// Access permission field and S/R encodings.
	localparam logic [1:0] AP_SYS_ONLY = 2'd0;
	localparam logic [1:0] AP_PRIV_RW  = 2'd1;
	localparam logic [1:0] AP_USER_RO  = 2'd2;
	localparam logic [1:0] SR_SYSTEM   = 2'd1;
	localparam logic [1:0] SR_ROM      = 2'd2;
	localparam int         PRINT_CAP   = 40;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] addr;
		fault_t      ft;
		logic        on_page;
		logic [3:0]  dom;
	} walk_result_t;

	logic [31:0]  l1_words [TABLE_ENTRIES];
	logic         walk_open;
	logic [31:0]  walk_va;
	logic         walk_wr;
	logic         walk_user;
	logic [3:0]   walk_dom;
	logic         mmu_on;
	logic [1:0]   sr_bits;
	logic [31:0]  dacr;
	walk_result_t due_results [$];
	int           n_err;
	int           n_rsp;
	int           n_ok;
	int           n_fetch;
	int           n_fault;

	function automatic walk_result_t make_result(kind_t k, logic [31:0] a, fault_t f,
			logic pg, logic [3:0] d);
		walk_result_t r;
		r.kind    = k;
		r.addr    = a;
		r.ft      = f;
		r.on_page = pg;
		r.dom     = d;
		return r;
	endfunction

	// Domain check, then permission check, then the physical address.
	function automatic walk_result_t grant_access(logic [31:0] va, logic wr, logic user,
			logic [3:0] dom, logic pg, logic [1:0] ap, logic [31:0] base, logic [31:0] mask);
		logic [1:0] da;
		logic       deny;
		da   = dacr[{dom, 1'b0} +: 2];
		deny = 1'b0;
		if (da != DA_MANAGER) begin
			if (!da[0])
				return make_result(KIND_FAULT, FAULT_ADDR, FT_DOMAIN, pg, dom);
			case (ap)
				AP_SYS_ONLY: begin
					case (sr_bits)
						SR_SYSTEM: deny = user | wr;
						SR_ROM:    deny = wr;
						default:   deny = 1'b1;
					endcase
				end
				AP_PRIV_RW: deny = user;
				AP_USER_RO: deny = wr & user;
				default:    deny = 1'b0;
			endcase
			if (deny)
				return make_result(KIND_FAULT, FAULT_ADDR, FT_PERMISSION, pg, dom);
		end
		return make_result(KIND_OK, (base & ~mask) | (va & mask), FT_NONE, 1'b0, 4'd0);
	endfunction

	// Applies one input item to the walker state and gives its result.
	function automatic walk_result_t walk_step(cmd_t c, logic [31:0] va, logic wr,
			logic user, logic [31:0] desc, logic [11:0] idx);
		logic [31:0] entry;
		logic [1:0]  ap;
		case (c)
			CMD_TRANSLATE: begin
				walk_open = 1'b0;
				if (!mmu_on)
					return make_result(KIND_OK, va, FT_NONE, 1'b0, 4'd0);
				entry = l1_words[va[31:20]];
				case (entry[1:0])
					L1_SECTION: begin
						return grant_access(va, wr, user, entry[8:5], 1'b0, entry[11:10],
							entry, MASK_SECTION);
					end
					L1_COARSE, L1_FINE: begin
						walk_open = 1'b1;
						walk_va   = va;
						walk_wr   = wr;
						walk_user = user;
						walk_dom  = entry[8:5];
						if (entry[1:0] == L1_COARSE)
							return make_result(KIND_FETCH, {entry[31:10], va[19:12], 2'b00},
								FT_NONE, 1'b0, 4'd0);
						return make_result(KIND_FETCH, {entry[31:12], va[19:10], 2'b00},
							FT_NONE, 1'b0, 4'd0);
					end
					default: return make_result(KIND_FAULT, FAULT_ADDR, FT_TRANSLATION, 1'b0,
						entry[8:5]);
				endcase
			end
			CMD_DESC: begin
				if (!walk_open)
					return make_result(KIND_ACCEPT, 32'd0, FT_NONE, 1'b0, 4'd0);
				walk_open = 1'b0;
				case (desc[1:0])
					L2_LARGE: begin
						ap = desc[4 + 2 * walk_va[15:14] +: 2];
						return grant_access(walk_va, walk_wr, walk_user, walk_dom, 1'b1, ap,
							desc, MASK_LARGE);
					end
					L2_SMALL: begin
						ap = desc[4 + 2 * walk_va[11:10] +: 2];
						return grant_access(walk_va, walk_wr, walk_user, walk_dom, 1'b1, ap,
							desc, MASK_SMALL);
					end
					L2_TINY: begin
						return grant_access(walk_va, walk_wr, walk_user, walk_dom, 1'b1,
							desc[5:4], desc, MASK_TINY);
					end
					default: return make_result(KIND_FAULT, FAULT_ADDR, FT_TRANSLATION, 1'b1,
						walk_dom);
				endcase
			end
			CMD_LOAD: begin
				l1_words[idx] = desc;
				return make_result(KIND_ACCEPT, 32'd0, FT_NONE, 1'b0, 4'd0);
			end
			default: return make_result(KIND_ACCEPT, 32'd0, FT_NONE, 1'b0, 4'd0);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (n_err < PRINT_CAP)
			$display("result %0d: %s is %h, expected %h", n_rsp, what, got, want);
		n_err++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		walk_result_t want;
		if (!arst_n) begin
			mmu_on    = 1'b0;
			sr_bits   = 2'd0;
			dacr      = 32'd0;
			walk_open = 1'b0;
			walk_va   = 32'd0;
			walk_wr   = 1'b0;
			walk_user = 1'b0;
			walk_dom  = 4'd0;
			due_results.delete();
		end else begin
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_idx))
					REG_MMU_ENABLE:    mmu_on  = cfg_wdata[0];
					REG_SYS_ROM:       sr_bits = cfg_wdata[1:0];
					REG_DOMAIN_ACCESS: dacr    = cfg_wdata;
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				due_results.push_back(walk_step(req.cmd, req.virt_addr, req.is_write,
					req.user_access, req.descriptor, req.table_index));
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing expected, out_addr", rsp.out_addr,
						32'd0);
				end else begin
					want = due_results.pop_front();
					if (rsp.result_kind !== want.kind)
						report_mismatch("result_kind", 32'(rsp.result_kind), 32'(want.kind));
					if (rsp.out_addr !== want.addr)
						report_mismatch("out_addr", rsp.out_addr, want.addr);
					if (rsp.fault_type !== want.ft)
						report_mismatch("fault_type", 32'(rsp.fault_type), 32'(want.ft));
					if (rsp.fault_on_page !== want.on_page)
						report_mismatch("fault_on_page", 32'(rsp.fault_on_page),
							32'(want.on_page));
					if (rsp.fault_domain !== want.dom)
						report_mismatch("fault_domain", 32'(rsp.fault_domain), 32'(want.dom));
					case (want.kind)
						KIND_OK:    n_ok++;
						KIND_FETCH: n_fetch++;
						KIND_FAULT: n_fault++;
						default: ;
					endcase
				end
				n_rsp++;
			end
		end
		outstanding <= due_results.size();
		errors      <= n_err;
		seen_ok     <= n_ok;
		seen_fetch  <= n_fetch;
		seen_fault  <= n_fault;
	end

endmodule

// ===== tb/sv/tb_armv5_mmu_page_walk_top.sv =====
// ----------------------------------------------------------------------------
// ARMv5 MMU page walk testbench
// Drives translate, descriptor and table load items into the walker under a
// series of register settings and handshake idling patterns, while a checker
// beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_armv5_mmu_page_walk_top;
	import a5mmu_pkg::*;

	// The watchdog gives up after this many cycles in which no item moves on
	// either channel. The slowest correct stretch is the long receiver
	// hold-off below, so this is many times over.
	localparam int   QUIET_LIMIT  = 2000;
	localparam int   HOLD_CYCLES  = 80;
	localparam int   RANDOM_ITEMS = 1500;
	localparam int   PHASES       = 8;
	localparam int   DRAIN_CYCLES = 4;
	localparam cmd_t CMD_UNUSED   = cmd_t'(2'd3);
	// Second-level type code for an invalid descriptor.
	localparam logic [1:0] L2_INVALID = 2'd0;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] va;
		logic        wr;
		logic        user;
		logic [31:0] desc;
		logic [11:0] idx;
	} walk_item_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_idx;
	logic [31:0] cfg_wdata;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_asks      = 0;
	int quiet          = 0;
	int items_sent     = 0;
	int settings       = 0;
	int outstanding;
	int errors;
	int seen_ok;
	int seen_fetch;
	int seen_fault;

	// First-level slots that have been written. Translate items only ever
	// address these, as a read of a slot never written is undefined.
	bit          slot_loaded [TABLE_ENTRIES];
	logic [11:0] loaded_slots [$];

	a5mmu_req_if req_ch ();
	a5mmu_rsp_if rsp_ch ();

	armv5_mmu_page_walk_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	tb_a5mmu_walk_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.outstanding (outstanding),
		.errors      (errors),
		.seen_ok     (seen_ok),
		.seen_fetch  (seen_fetch),
		.seen_fault  (seen_fault)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Receiver side. Ready is redrawn every cycle from the current stall
	// percentage. When the stimulus asks for a hold-off, ready stays low for a
	// long stretch counted here, so that the block fills and stalls its input.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: a run in which nothing moves for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Offers one item, after a random number of idle cycles, and returns at
	// the edge where it is taken. Valid stays high into the next item unless
	// that one begins with a gap.
	task automatic send(input walk_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= it.cmd;
		req_ch.virt_addr   <= it.va;
		req_ch.is_write    <= it.wr;
		req_ch.user_access <= it.user;
		req_ch.descriptor  <= it.desc;
		req_ch.table_index <= it.idx;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	// Every field random; callers then set the ones that matter.
	function automatic walk_item_t filler(cmd_t c);
		walk_item_t it;
		it.cmd  = c;
		it.va   = $urandom;
		it.wr   = 1'($urandom_range(1));
		it.user = 1'($urandom_range(1));
		it.desc = $urandom;
		it.idx  = 12'($urandom_range(TABLE_ENTRIES - 1));
		return it;
	endfunction

	task automatic xlate(logic [31:0] va, logic wr, logic user);
		walk_item_t it;
		it      = filler(CMD_TRANSLATE);
		it.va   = va;
		it.wr   = wr;
		it.user = user;
		send(it);
	endtask

	task automatic give_desc(logic [31:0] d);
		walk_item_t it;
		it      = filler(CMD_DESC);
		it.desc = d;
		send(it);
	endtask

	task automatic load_slot(logic [11:0] idx, logic [31:0] d);
		walk_item_t it;
		it      = filler(CMD_LOAD);
		it.idx  = idx;
		it.desc = d;
		send(it);
		if (!slot_loaded[idx]) begin
			slot_loaded[idx] = 1'b1;
			loaded_slots.push_back(idx);
		end
	endtask

	// Lowers valid, waits until every result has come back and then lets the
	// pipeline empty, so registers can be rewritten safely.
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic mmu, logic [1:0] sr, logic [31:0] da);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= REG_MMU_ENABLE;
		cfg_wdata <= {31'd0, mmu};
		@(posedge clk);
		cfg_idx   <= REG_SYS_ROM;
		cfg_wdata <= {30'd0, sr};
		@(posedge clk);
		cfg_idx   <= REG_DOMAIN_ACCESS;
		cfg_wdata <= da;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	// Virtual address that falls in a written first-level slot.
	function automatic logic [31:0] rand_va();
		logic [31:0] r;
		r = $urandom;
		return {loaded_slots[$urandom_range(loaded_slots.size() - 1)], r[19:0]};
	endfunction

	// First-level word, weighted towards descriptors that open a walk.
	function automatic logic [31:0] rand_l1();
		logic [31:0] w;
		int          t;
		w = $urandom;
		t = $urandom_range(9);
		if (t == 0)
			w[1:0] = L1_FAULT;
		else if (t < 4)
			w[1:0] = L1_COARSE;
		else if (t < 7)
			w[1:0] = L1_SECTION;
		else
			w[1:0] = L1_FINE;
		return w;
	endfunction

	function automatic logic [31:0] rand_l2();
		logic [31:0] w;
		int          t;
		w = $urandom;
		t = $urandom_range(9);
		if (t == 0)
			w[1:0] = L2_INVALID;
		else if (t < 4)
			w[1:0] = L2_LARGE;
		else if (t < 7)
			w[1:0] = L2_SMALL;
		else
			w[1:0] = L2_TINY;
		return w;
	endfunction

	initial begin
		int          per_phase;
		int          done;
		int          pick;
		logic [11:0] idx;
		logic [31:0] da;

		arst_n             <= 1'b0;
		cfg_wr_en          <= 1'b0;
		cfg_idx            <= REG_MMU_ENABLE;
		cfg_wdata          <= 32'd0;
		req_ch.valid       <= 1'b0;
		req_ch.cmd         <= CMD_TRANSLATE;
		req_ch.virt_addr   <= 32'd0;
		req_ch.is_write    <= 1'b0;
		req_ch.user_access <= 1'b0;
		req_ch.descriptor  <= 32'd0;
		req_ch.table_index <= 12'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The registers still hold their reset values, so the
		// MMU is off. Fill a handful of slots first: a coarse table at slot 0
		// in domain 5, a fine table at slot 1 in domain 3, an invalid word at
		// slot 2, sections at slots 3 (AP zero, domain 2) and 4 (AP full,
		// domain 1), and an all-ones fine descriptor in the last slot.
		load_slot(12'd0, 32'h0012_34A1);
		load_slot(12'hFFF, 32'hFFFF_FFFF);
		load_slot(12'd1, 32'h0ABC_D063);
		load_slot(12'd2, 32'h0000_0000);
		load_slot(12'd3, 32'h3000_0042);
		load_slot(12'd4, 32'h4000_0C22);

		// With the MMU off addresses come straight back. An unused command
		// and a descriptor with no walk open are only acknowledged.
		xlate(32'hFFFF_FFFF, 1'b1, 1'b1);
		xlate(32'h0000_0000, 1'b0, 1'b0);
		send(filler(CMD_UNUSED));
		give_desc(32'hFFFF_FFFF);
		settle();

		// MMU on, every domain manager: walks of each page size go through.
		set_config(1'b1, 2'd0, 32'hFFFF_FFFF);
		// Coarse walk; a table load in the middle leaves the walk open, and a
		// large page completes it.
		xlate(32'h0000_5678, 1'b0, 1'b0);
		load_slot(12'd6, 32'h0060_0C02);
		give_desc(32'h1234_FFF5);
		// A fine walk dropped by a new translate: the section hit answers at
		// once and the late descriptor is only acknowledged.
		xlate(32'h001F_FC00, 1'b1, 1'b0);
		xlate(32'h004A_BCDE, 1'b0, 1'b1);
		give_desc(32'h5555_5556);
		// Small page through the all-ones fine table, then a tiny page.
		xlate(32'hFFF0_0ABC, 1'b1, 1'b1);
		give_desc(32'hABCD_E00E);
		xlate(32'h000F_FFFF, 1'b0, 1'b0);
		give_desc(32'hFFFF_FFFF);
		// Invalid second-level word, then an invalid first-level slot.
		xlate(32'h0000_1000, 1'b0, 1'b0);
		give_desc(32'hFFFF_FFFC);
		xlate(32'h0020_0000, 1'b0, 1'b0);

		// Open a walk, let the block go idle, and change the registers before
		// the descriptor arrives: the walk must finish under the new values.
		// S and R both set is the reserved case and denies AP zero outright.
		xlate(32'h0001_2000, 1'b1, 1'b1);
		settle();
		set_config(1'b1, 2'b11, 32'h5555_5555);
		give_desc(32'h0000_000E);
		xlate(32'h0030_0000, 1'b0, 1'b0);
		settle();

		// No domain access at all gives a domain fault.
		set_config(1'b1, 2'd0, 32'h0000_0000);
		xlate(32'h0040_0000, 1'b0, 1'b0);

		// Random part. Each phase picks its own register values and idling
		// pattern; most items form translate-then-descriptor walks over a
		// growing set of random first-level words, the rest is noise.
		per_phase = RANDOM_ITEMS / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 3)
				0:       da = $urandom | 32'h5555_5555;
				1:       da = $urandom;
				default: da = 32'h5555_5555;
			endcase
			set_config(p != 1, p[1:0], da);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 53;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 53;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct <= 38;
				end
			endcase
			// One phase with no sender gaps starts with a long hold-off.
			if (p == 4)
				hold_asks <= hold_asks + 1;
			done = 0;
			while (done < per_phase) begin
				pick = $urandom_range(99);
				if (pick < 12) begin
					if (loaded_slots.size() < 64 || $urandom_range(3) == 0)
						idx = 12'($urandom_range(TABLE_ENTRIES - 1));
					else
						idx = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
					load_slot(idx, rand_l1());
					done++;
				end else if (pick < 72) begin
					xlate(rand_va(), 1'($urandom_range(1)), 1'($urandom_range(1)));
					done++;
					if ($urandom_range(99) < 85) begin
						give_desc(rand_l2());
						done++;
					end
				end else if (pick < 80) begin
					xlate(rand_va(), 1'($urandom_range(1)), 1'($urandom_range(1)));
					done++;
				end else if (pick < 86) begin
					// A stray descriptor: often ignored, so it is not counted.
					give_desc(rand_l2());
				end else if (pick < 91) begin
					send(filler(CMD_UNUSED));
				end else begin
					xlate(rand_va(), 1'($urandom_range(1)), 1'($urandom_range(1)));
					xlate(rand_va(), 1'($urandom_range(1)), 1'($urandom_range(1)));
					done += 2;
				end
			end
		end

		settle();
		$display("Run covered %0d input items under %0d register settings, idle patterns "
			, items_sent, settings);
		$display("and one long receiver hold-off: %0d translated, %0d fetches, %0d faults.",
			seen_ok, seen_fetch, seen_fault);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
